FILE: rtl/hga_pkg.sv
`default_nettype none

package hga_pkg;

    localparam int STEP_BITS      = 5;
    localparam int REG_INDEX_BITS = 3;

    typedef logic [STEP_BITS-1:0]      step_t;
    typedef logic [REG_INDEX_BITS-1:0] reg_index_t;

    // Configuration register indexes.
    localparam reg_index_t REG_HIGHPASS_ENABLE      = 3'd0;
    localparam reg_index_t REG_AGC_ENABLE           = 3'd1;
    localparam reg_index_t REG_GATE_ENABLE          = 3'd2;
    localparam reg_index_t REG_GATE_LEVEL           = 3'd3;
    localparam reg_index_t REG_HIGHPASS_COEFFICIENT = 3'd4;

    // Datapath operations, one per control word.
    typedef enum logic [4:0] {
        OP_NOP,
        OP_LOAD,
        OP_HP_MUL,
        OP_ROUND,
        OP_HP_WB,
        OP_Y_BYPASS,
        OP_ENV_MUL,
        OP_ENV_WB,
        OP_DIV_START,
        OP_TGT_DIV,
        OP_TGT_ONE,
        OP_SLEW_MUL,
        OP_GAIN_WB,
        OP_OUT_MUL,
        OP_OUT_WB,
        OP_OUT_BYPASS,
        OP_EMIT
    } op_t;

    // Jump conditions; a true condition loads the target, otherwise the step advances.
    typedef enum logic [3:0] {
        COND_NEXT,
        COND_ALWAYS,
        COND_NO_INPUT,
        COND_HP_OFF,
        COND_GA_OFF,
        COND_AGC_OFF,
        COND_ENV_LOW,
        COND_DIV_BUSY,
        COND_OUT_FULL
    } cond_t;

    typedef struct packed {
        op_t   op;
        cond_t cond;
        step_t target;
        logic  shift_gain;
    } ctrl_t;

    typedef struct packed {
        logic in_valid;
        logic hp_on;
        logic gate_on;
        logic agc_on;
        logic env_low;
        logic div_busy;
        logic out_full;
    } flags_t;

    // Program addresses.
    localparam step_t STEP_IDLE        = 5'd0;
    localparam step_t STEP_HP_MUL      = 5'd1;
    localparam step_t STEP_HP_ROUND    = 5'd2;
    localparam step_t STEP_HP_WB       = 5'd3;
    localparam step_t STEP_HP_BYPASS   = 5'd4;
    localparam step_t STEP_ENV_MUL     = 5'd5;
    localparam step_t STEP_ENV_ROUND   = 5'd6;
    localparam step_t STEP_ENV_WB      = 5'd7;
    localparam step_t STEP_DIV_START   = 5'd8;
    localparam step_t STEP_DIV_WAIT    = 5'd9;
    localparam step_t STEP_TGT_DIV     = 5'd10;
    localparam step_t STEP_TGT_ONE     = 5'd11;
    localparam step_t STEP_SLEW_MUL    = 5'd12;
    localparam step_t STEP_SLEW_ROUND  = 5'd13;
    localparam step_t STEP_GAIN_WB     = 5'd14;
    localparam step_t STEP_OUT_MUL     = 5'd15;
    localparam step_t STEP_OUT_ROUND   = 5'd16;
    localparam step_t STEP_OUT_WB      = 5'd17;
    localparam step_t STEP_OUT_BYPASS  = 5'd18;
    localparam step_t STEP_EMIT        = 5'd19;
    localparam step_t STEP_RETURN      = 5'd20;

    function automatic ctrl_t hga_rom(input step_t addr);
        ctrl_t cw;
        cw = '{OP_NOP, COND_ALWAYS, STEP_IDLE, 1'b0};
        unique case (addr)
            STEP_IDLE:       cw = '{OP_LOAD,       COND_NO_INPUT, STEP_IDLE,       1'b0};
            STEP_HP_MUL:     cw = '{OP_HP_MUL,     COND_HP_OFF,   STEP_HP_BYPASS,  1'b0};
            STEP_HP_ROUND:   cw = '{OP_ROUND,      COND_NEXT,     STEP_IDLE,       1'b0};
            STEP_HP_WB:      cw = '{OP_HP_WB,      COND_ALWAYS,   STEP_ENV_MUL,    1'b0};
            STEP_HP_BYPASS:  cw = '{OP_Y_BYPASS,   COND_NEXT,     STEP_IDLE,       1'b0};
            STEP_ENV_MUL:    cw = '{OP_ENV_MUL,    COND_GA_OFF,   STEP_OUT_BYPASS, 1'b0};
            STEP_ENV_ROUND:  cw = '{OP_ROUND,      COND_NEXT,     STEP_IDLE,       1'b0};
            STEP_ENV_WB:     cw = '{OP_ENV_WB,     COND_AGC_OFF,  STEP_OUT_MUL,    1'b0};
            STEP_DIV_START:  cw = '{OP_DIV_START,  COND_ENV_LOW,  STEP_TGT_ONE,    1'b0};
            STEP_DIV_WAIT:   cw = '{OP_NOP,        COND_DIV_BUSY, STEP_DIV_WAIT,   1'b0};
            STEP_TGT_DIV:    cw = '{OP_TGT_DIV,    COND_ALWAYS,   STEP_SLEW_MUL,   1'b0};
            STEP_TGT_ONE:    cw = '{OP_TGT_ONE,    COND_NEXT,     STEP_IDLE,       1'b0};
            STEP_SLEW_MUL:   cw = '{OP_SLEW_MUL,   COND_NEXT,     STEP_IDLE,       1'b0};
            STEP_SLEW_ROUND: cw = '{OP_ROUND,      COND_NEXT,     STEP_IDLE,       1'b0};
            STEP_GAIN_WB:    cw = '{OP_GAIN_WB,    COND_NEXT,     STEP_IDLE,       1'b0};
            STEP_OUT_MUL:    cw = '{OP_OUT_MUL,    COND_NEXT,     STEP_IDLE,       1'b0};
            STEP_OUT_ROUND:  cw = '{OP_ROUND,      COND_NEXT,     STEP_IDLE,       1'b1};
            STEP_OUT_WB:     cw = '{OP_OUT_WB,     COND_ALWAYS,   STEP_EMIT,       1'b0};
            STEP_OUT_BYPASS: cw = '{OP_OUT_BYPASS, COND_NEXT,     STEP_IDLE,       1'b0};
            STEP_EMIT:       cw = '{OP_EMIT,       COND_OUT_FULL, STEP_EMIT,       1'b0};
            STEP_RETURN:     cw = '{OP_NOP,        COND_ALWAYS,   STEP_IDLE,       1'b0};
            default:         cw = '{OP_NOP,        COND_ALWAYS,   STEP_IDLE,       1'b0};
        endcase
        return cw;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/hga_in_if.sv
`default_nettype none

interface hga_in_if #(parameter int SAMPLE_BITS = 24);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample_in;

    modport source (output valid, output sample_in, input ready);
    modport sink (input valid, input sample_in, output ready);
endinterface

`default_nettype wire

FILE: rtl/hga_out_if.sv
`default_nettype none

interface hga_out_if #(parameter int SAMPLE_BITS = 24);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample_out;

    modport source (output valid, output sample_out, input ready);
    modport sink (input valid, input sample_out, output ready);
endinterface

`default_nettype wire

FILE: rtl/hga_seq.sv
`default_nettype none

module hga_seq (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  hga_pkg::flags_t     flags,
    output hga_pkg::ctrl_t      ctrl
);

    hga_pkg::step_t step_reg;
    hga_pkg::step_t step_next;
    logic           jump;

    assign ctrl = hga_pkg::hga_rom(step_reg);

    always_comb
    begin
        unique case (ctrl.cond)
            hga_pkg::COND_NEXT:     jump = 1'b0;
            hga_pkg::COND_ALWAYS:   jump = 1'b1;
            hga_pkg::COND_NO_INPUT: jump = !flags.in_valid;
            hga_pkg::COND_HP_OFF:   jump = !flags.hp_on;
            hga_pkg::COND_GA_OFF:   jump = !flags.gate_on && !flags.agc_on;
            hga_pkg::COND_AGC_OFF:  jump = !flags.agc_on;
            hga_pkg::COND_ENV_LOW:  jump = flags.env_low;
            hga_pkg::COND_DIV_BUSY: jump = flags.div_busy;
            hga_pkg::COND_OUT_FULL: jump = flags.out_full;
            default:                jump = 1'b1;
        endcase
        step_next = jump ? ctrl.target : hga_pkg::step_t'(step_reg + 1'b1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= hga_pkg::STEP_IDLE;
        end
        else
        begin
            step_reg <= step_next;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/hga_div.sv
`default_nettype none

// Restoring divider, one quotient bit per cycle. The caller guarantees that the
// quotient fits in QUOT_BITS, so only the low QUOT_BITS numerator bits are iterated.
module hga_div #(
    parameter int NUM_BITS  = 42,
    parameter int DEN_BITS  = 24,
    parameter int QUOT_BITS = 25
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 start,
    input  wire logic [NUM_BITS-1:0]  num,
    input  wire logic [DEN_BITS-1:0]  den,
    output logic                      busy,
    output logic [QUOT_BITS-1:0]      quot
);

    localparam int CNT_BITS = $clog2(QUOT_BITS + 1);

    logic [CNT_BITS-1:0]  count_reg;
    logic [DEN_BITS-1:0]  rem_reg;
    logic [DEN_BITS-1:0]  den_reg;
    logic [QUOT_BITS-1:0] quot_reg;
    logic [DEN_BITS:0]    trial;
    logic                 fits;

    assign busy  = (count_reg != '0);
    assign quot  = quot_reg;
    assign trial = {rem_reg, quot_reg[QUOT_BITS-1]};
    assign fits  = (trial >= {1'b0, den_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (start)
        begin
            count_reg <= CNT_BITS'(QUOT_BITS);
        end
        else if (busy)
        begin
            count_reg <= count_reg - 1'b1;
        end
    end

    // The quotient shifts in where the numerator's low bits shift out.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg  <= DEN_BITS'(num >> QUOT_BITS);
            den_reg  <= den;
            quot_reg <= num[QUOT_BITS-1:0];
        end
        else if (busy)
        begin
            rem_reg  <= fits ? DEN_BITS'(trial - {1'b0, den_reg}) : trial[DEN_BITS-1:0];
            quot_reg <= {quot_reg[QUOT_BITS-2:0], fits};
        end
    end

endmodule

`default_nettype wire

FILE: rtl/hga_dp.sv
`default_nettype none

module hga_dp #(
    parameter int SAMPLE_BITS    = 24,
    parameter int GAIN_FRAC_BITS = 20
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  hga_pkg::ctrl_t              ctrl,
    input  wire logic [SAMPLE_BITS-1:0] sample_in,
    input  wire logic [SAMPLE_BITS-2:0] hp_coef,
    input  wire logic [SAMPLE_BITS-2:0] gate_level,
    input  wire logic                   gate_enable,
    output logic                        env_low,
    output logic                        div_busy,
    output logic [SAMPLE_BITS-1:0]      res
);

    localparam int S  = SAMPLE_BITS;
    localparam int G  = GAIN_FRAC_BITS;
    localparam int F  = S - 1;
    localparam int GW = G + 4;
    localparam int MA = (F > GW) ? F : GW;
    localparam int MB = (S + 1 > GW) ? S + 1 : GW;
    localparam int PW = MA + MB;
    localparam int RW = (S + 5 > GW) ? S + 5 : GW;
    localparam int QW = G + 5;
    localparam int NW = G + F - 1;

    localparam longint unsigned ONE_F = 64'd1 << F;
    localparam logic [F-1:0]  C_ATTACK  = F'(((ONE_F << 2) + 64'd5) / 64'd10);
    localparam logic [F-1:0]  C_RELEASE = F'((ONE_F + 64'd100) / 64'd200);
    localparam logic [F-1:0]  C_SLEW    = F'((ONE_F + 64'd1000) / 64'd2000);
    localparam logic [S-1:0]  C_LOW_ENV = S'((ONE_F + 64'd50) / 64'd100);
    localparam logic [GW-1:0] GAIN_ONE  = GW'(1) << G;
    localparam logic [GW-1:0] GAIN_MAX  = GW'(8) << G;
    localparam logic [NW-1:0] DIV_BASE  = NW'(1) << (NW - 1);
    localparam logic [PW:0]   HALF_F    = (PW + 1)'(1) << (F - 1);
    localparam logic [PW:0]   HALF_G    = (PW + 1)'(1) << (G - 1);

    // Architectural state.
    logic [S:0]    fop_reg;
    logic [S-1:0]  fip_reg;
    logic [S-1:0]  env_reg;
    logic [GW-1:0] gain_reg;

    // Working registers.
    logic [S-1:0]  x_reg;
    logic [S:0]    y_reg;
    logic [GW-1:0] target_reg;
    logic [PW-1:0] prod_reg;
    logic          neg_reg;
    logic [RW:0]   rnd_reg;
    logic [S-1:0]  res_reg;

    logic [S+1:0]  hp_delta;
    logic [S+1:0]  hp_abs;
    logic [S:0]    y_abs;
    logic [S-1:0]  ax;
    logic [S:0]    env_delta;
    logic [S:0]    env_abs;
    logic [GW:0]   gain_delta;
    logic [GW:0]   gain_abs;
    logic [MA-1:0] mul_a;
    logic [MB-1:0] mul_b;
    logic          mul_neg;
    logic          mul_load;
    logic [PW:0]   sum_f;
    logic [PW:0]   sum_g;
    logic [RW-1:0] rnd_mag;
    logic          rnd_sign;
    logic [S:0]    rnd_sat_wide;
    logic [S-1:0]  rnd_sat;
    logic [S-1:0]  y_sat;
    logic [RW:0]   env_sum;
    logic [RW:0]   gain_sum;
    logic          gate_open;
    logic          div_start;
    logic [NW-1:0] div_num;
    logic [QW-1:0] div_quot;

    hga_div #(
        .NUM_BITS  (NW),
        .DEN_BITS  (S),
        .QUOT_BITS (QW)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (env_reg),
        .busy  (div_busy),
        .quot  (div_quot)
    );

    assign div_start = (ctrl.op == hga_pkg::OP_DIV_START);
    assign div_num   = DIV_BASE + NW'(env_reg >> 1);
    assign env_low   = (env_reg <= C_LOW_ENV);
    assign gate_open = (env_reg > S'(gate_level));
    assign res       = res_reg;

    always_comb
    begin
        hp_delta   = {fop_reg[S], fop_reg} + {{2{x_reg[S-1]}}, x_reg}
                     - {{2{fip_reg[S-1]}}, fip_reg};
        hp_abs     = hp_delta[S+1] ? -hp_delta : hp_delta;
        y_abs      = y_reg[S] ? -y_reg : y_reg;
        // A magnitude of exactly full scale does not fit the envelope width.
        ax         = y_abs[S] ? {S{1'b1}} : y_abs[S-1:0];
        env_delta  = {1'b0, ax} - {1'b0, env_reg};
        env_abs    = env_delta[S] ? -env_delta : env_delta;
        gain_delta = {1'b0, target_reg} - {1'b0, gain_reg};
        gain_abs   = gain_delta[GW] ? -gain_delta : gain_delta;

        mul_a    = MA'(gain_reg);
        mul_b    = MB'(y_abs);
        mul_neg  = y_reg[S];
        mul_load = 1'b0;
        unique case (ctrl.op)
            hga_pkg::OP_HP_MUL:
            begin
                mul_a    = MA'(hp_coef);
                mul_b    = MB'(hp_abs[S:0]);
                mul_neg  = hp_delta[S+1];
                mul_load = 1'b1;
            end
            hga_pkg::OP_ENV_MUL:
            begin
                mul_a    = (ax > env_reg) ? MA'(C_ATTACK) : MA'(C_RELEASE);
                mul_b    = MB'(env_abs[S-1:0]);
                mul_neg  = env_delta[S];
                mul_load = 1'b1;
            end
            hga_pkg::OP_SLEW_MUL:
            begin
                mul_a    = MA'(C_SLEW);
                mul_b    = MB'(gain_abs[GW-1:0]);
                mul_neg  = gain_delta[GW];
                mul_load = 1'b1;
            end
            hga_pkg::OP_OUT_MUL:
            begin
                mul_load = 1'b1;
            end
            default:
            begin
                mul_load = 1'b0;
            end
        endcase
    end

    // Rounding is half away from zero: the magnitude is rounded, then the sign applied.
    always_comb
    begin
        sum_f   = {1'b0, prod_reg} + HALF_F;
        sum_g   = {1'b0, prod_reg} + HALF_G;
        rnd_mag = ctrl.shift_gain ? RW'(sum_g >> G) : RW'(sum_f >> F);

        rnd_sign     = rnd_reg[RW];
        rnd_sat_wide = (rnd_reg[RW:S] == {(RW - S + 1){rnd_sign}})
                       ? rnd_reg[S:0] : {rnd_sign, {S{~rnd_sign}}};
        rnd_sat      = (rnd_reg[RW:S-1] == {(RW - S + 2){rnd_sign}})
                       ? rnd_reg[S-1:0] : {rnd_sign, {(S - 1){~rnd_sign}}};
        y_sat        = (y_reg[S] == y_reg[S-1])
                       ? y_reg[S-1:0] : {y_reg[S], {(S - 1){~y_reg[S]}}};

        env_sum  = {{(RW + 1 - S){1'b0}}, env_reg} + rnd_reg;
        gain_sum = {{(RW + 1 - GW){1'b0}}, gain_reg} + rnd_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fop_reg  <= '0;
            fip_reg  <= '0;
            env_reg  <= '0;
            gain_reg <= GAIN_ONE;
        end
        else
        begin
            unique case (ctrl.op)
                hga_pkg::OP_HP_WB:
                begin
                    fop_reg <= rnd_sat_wide;
                    fip_reg <= x_reg;
                end
                hga_pkg::OP_ENV_WB:
                begin
                    env_reg <= env_sum[S-1:0];
                end
                hga_pkg::OP_GAIN_WB:
                begin
                    gain_reg <= gain_sum[GW-1:0];
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (mul_load)
        begin
            prod_reg <= mul_a * mul_b;
            neg_reg  <= mul_neg;
        end
        unique case (ctrl.op)
            hga_pkg::OP_LOAD:       x_reg      <= sample_in;
            hga_pkg::OP_ROUND:      rnd_reg    <= neg_reg ? -{1'b0, rnd_mag} : {1'b0, rnd_mag};
            hga_pkg::OP_HP_WB:      y_reg      <= rnd_sat_wide;
            hga_pkg::OP_Y_BYPASS:   y_reg      <= {x_reg[S-1], x_reg};
            hga_pkg::OP_TGT_DIV:    target_reg <= (div_quot > QW'(GAIN_MAX))
                                                  ? GAIN_MAX : div_quot[GW-1:0];
            hga_pkg::OP_TGT_ONE:    target_reg <= GAIN_ONE;
            hga_pkg::OP_OUT_WB:     res_reg    <= (gate_enable && !gate_open) ? '0 : rnd_sat;
            hga_pkg::OP_OUT_BYPASS: res_reg    <= y_sat;
            default:
            begin
            end
        endcase
    end

endmodule

`default_nettype wire

FILE: rtl/hpf_gate_agc_audio_conditioner.sv
// One-pole high-pass, envelope noise gate and automatic gain for Q1.F audio.
// Samples arrive on the samples channel and leave on the conditioned channel,
// both valid/ready; a request moves when valid and ready are high at a clock edge.
// One sample is in work at a time: the input is ready only while the control
// program sits at its idle step. With the gain control enabled and the envelope
// above the low-level knee, a sample passes the high-pass, envelope, gain-target
// division, gain slew and output steps, and after the emit step the program goes
// back to idle through its return step. The gain-target divider retires one
// quotient bit per cycle. Below the knee the divider is skipped; with the gain
// control off the gain steps are skipped, and with both the gate and the gain
// control off the envelope update and output multiply too. A bypassed high-pass copies the input instead of rounding.
// The result sits in an output register, so the block takes the next sample while
// that result waits; when the receiver stalls, the program holds at its emit step
// until the register drains.
// Configuration is written through cfg_write_enable, cfg_index and cfg_write_data,
// by the user only while no sample is in work; the block does not enforce it.
// Reset clears the filter history and envelope, sets gain 1.0, loads register defaults.
`default_nettype none

module hpf_gate_agc_audio_conditioner #(
    parameter int SAMPLE_BITS    = 24,
    parameter int GAIN_FRAC_BITS = 20
) (
    input  wire logic                                    clk,
    input  wire logic                                    rst_n,
    hga_in_if.sink                                       samples,
    hga_out_if.source                                    conditioned,
    input  wire logic                                    cfg_write_enable,
    input  wire logic [hga_pkg::REG_INDEX_BITS-1:0]      cfg_index,
    input  wire logic [SAMPLE_BITS-2:0]                  cfg_write_data
);

    localparam int F = SAMPLE_BITS - 1;
    localparam longint unsigned ONE_F     = 64'd1 << F;
    localparam longint unsigned RELEASE_F = (ONE_F + 64'd100) / 64'd200;
    localparam logic [F-1:0] GATE_LEVEL_RESET = F'(RELEASE_F);
    localparam logic [F-1:0] COEF_RESET       = F'(ONE_F - RELEASE_F);

    logic                   hp_enable_reg;
    logic                   agc_enable_reg;
    logic                   gate_enable_reg;
    logic [F-1:0]           gate_level_reg;
    logic [F-1:0]           hp_coef_reg;
    logic                   out_valid_reg;
    logic [SAMPLE_BITS-1:0] out_sample_reg;

    hga_pkg::ctrl_t         ctrl;
    hga_pkg::flags_t        flags;
    logic                   env_low;
    logic                   div_busy;
    logic                   out_full;
    logic                   emit;
    logic [SAMPLE_BITS-1:0] res;

    assign out_full = out_valid_reg && !conditioned.ready;
    assign emit     = (ctrl.op == hga_pkg::OP_EMIT) && !out_full;

    assign samples.ready          = (ctrl.op == hga_pkg::OP_LOAD);
    assign conditioned.valid      = out_valid_reg;
    assign conditioned.sample_out = out_sample_reg;

    always_comb
    begin
        flags.in_valid = samples.valid;
        flags.hp_on    = hp_enable_reg;
        flags.gate_on  = gate_enable_reg;
        flags.agc_on   = agc_enable_reg;
        flags.env_low  = env_low;
        flags.div_busy = div_busy;
        flags.out_full = out_full;
    end

    hga_seq u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .flags (flags),
        .ctrl  (ctrl)
    );

    hga_dp #(
        .SAMPLE_BITS    (SAMPLE_BITS),
        .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctrl        (ctrl),
        .sample_in   (samples.sample_in),
        .hp_coef     (hp_coef_reg),
        .gate_level  (gate_level_reg),
        .gate_enable (gate_enable_reg),
        .env_low     (env_low),
        .div_busy    (div_busy),
        .res         (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hp_enable_reg   <= 1'b1;
            agc_enable_reg  <= 1'b1;
            gate_enable_reg <= 1'b1;
            gate_level_reg  <= GATE_LEVEL_RESET;
            hp_coef_reg     <= COEF_RESET;
        end
        else if (cfg_write_enable)
        begin
            unique case (cfg_index)
                hga_pkg::REG_HIGHPASS_ENABLE:      hp_enable_reg   <= cfg_write_data[0];
                hga_pkg::REG_AGC_ENABLE:           agc_enable_reg  <= cfg_write_data[0];
                hga_pkg::REG_GATE_ENABLE:          gate_enable_reg <= cfg_write_data[0];
                hga_pkg::REG_GATE_LEVEL:           gate_level_reg  <= cfg_write_data;
                hga_pkg::REG_HIGHPASS_COEFFICIENT: hp_coef_reg     <= cfg_write_data;
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (conditioned.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_sample_reg <= res;
        end
    end

endmodule

`default_nettype wire
